/* sv/gbdo_pkg.sv */
// gbdo_pkg: shared types and constants for graph_bfs_dfs_order.
// Used by gbdo_out_fifo and graph_bfs_dfs_order; depends on nothing.
package gbdo_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 256;
  localparam int ENTRY_COUNT = 2 * MAX_EDGES;
  localparam int NODE_W      = 6;
  localparam int NA_W        = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int EA_W        = $clog2(ENTRY_COUNT);
  localparam int CUR_W       = EA_W + 1;
  localparam int ET_W        = $clog2(MAX_EDGES + 1);
  localparam logic [CUR_W-1:0] NIL_ENTRY = CUR_W'(ENTRY_COUNT);

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_ADD_C,
    ST_BFS_POP,
    ST_BFS_HEAD,
    ST_BFS_CUR,
    ST_BFS_NB,
    ST_DFS_INIT,
    ST_DFS_STEP,
    ST_DFS_POP,
    ST_DFS_NB,
    ST_DFS_PUSH,
    ST_RUN_END
  } state_e;

  typedef struct packed {
    logic [NODE_W-1:0] vertex;
    logic              last;
    logic              dropped;
  } out_beat_t;

endpackage

/* sv/gbdo_out_fifo.sv */
// gbdo_out_fifo: two-entry result buffer between the sequencer and the output channel.
// Depends on gbdo_pkg for the result beat type.
module gbdo_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gbdo_pkg::out_beat_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                stall_i,
  output gbdo_pkg::out_beat_t data_o
);
  import gbdo_pkg::*;

  out_beat_t  slot_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = slot_q[rp_q];
  assign pop     = valid_o && !stall_i;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o || pop)
    else $error("beat pushed into full buffer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == 2'd0) |-> (wp_q == rp_q))
    else $error("empty buffer with misaligned pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("buffer count overrun");

endmodule

/* sv/graph_bfs_dfs_order.sv */
// Breadth-first / depth-first traversal of an undirected graph held in adjacency lists.
// Adding an edge does a tail read and a link write for each endpoint through the head/tail
// and entry memories. A run starts in the cycle after acceptance, and the entry memory walk
// uses registered reads; the next item is taken once the run has handed its last vertex to
// the output buffer. Depends on gbdo_pkg and gbdo_out_fifo.
module graph_bfs_dfs_order (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [gbdo_pkg::NODE_W-1:0] end_a_i,
  input  logic [gbdo_pkg::NODE_W-1:0] end_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gbdo_pkg::NODE_W-1:0] vertex_o,
  output logic                        last_o,
  output logic                        edges_dropped_o
);
  import gbdo_pkg::*;

  state_e state_q, state_d;
  logic   mode_q;
  logic [MAX_NODES-1:0] valid_q, valid_d, visited_q, visited_d;
  logic [ET_W-1:0]  edge_total_q, edge_total_d;
  logic             ovf_q, ovf_d;
  logic [NA_W-1:0]  a_q, a_d, b_q, b_d;
  logic [CNT_W-1:0] rd_q, rd_d, wr_q, wr_d, depth_q, depth_d;
  logic [CUR_W-1:0] top_q, top_d;
  logic             hv_q, hv_d;
  logic             hold_v_q, hold_v_d;
  logic [NA_W-1:0]  hold_q, hold_d;

  logic [CUR_W-1:0] head_mem [MAX_NODES];
  logic [CUR_W-1:0] tail_mem [MAX_NODES];
  logic [NA_W-1:0]  nb_mem   [ENTRY_COUNT];
  logic [CUR_W-1:0] link_mem [ENTRY_COUNT];
  logic [NA_W-1:0]  fifo_mem [MAX_NODES];
  logic [CUR_W-1:0] stack_mem [MAX_NODES];

  logic             hd_we, hd_re, tl_we, tl_re, nb_we, lk_we, en_re;
  logic             fq_we, fq_re, st_we, st_re;
  logic [NA_W-1:0]  hd_wa, hd_ra, tl_wa, tl_ra, fq_wa, fq_ra, fq_wd, st_wa, st_ra;
  logic [EA_W-1:0]  nb_wa, lk_wa, en_ra;
  logic [NA_W-1:0]  nb_wd;
  logic [CUR_W-1:0] hd_wd, tl_wd, lk_wd, st_wd;
  logic [CUR_W-1:0] hd_rdata_q, tl_rdata_q, lk_rdata_q, st_rdata_q;
  logic [NA_W-1:0]  nb_rdata_q, fq_rdata_q;

  logic             in_acc, range_ok, edge_full, emit_ok, of_full, of_push;
  logic             nb_fresh;
  out_beat_t        of_data, of_out;
  logic [CUR_W-1:0] e0, e1;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign range_ok    = (CNT_W'(end_a_i) < CNT_W'(MAX_NODES)) &&
                       (CNT_W'(end_b_i) < CNT_W'(MAX_NODES));
  assign edge_full   = (edge_total_q >= ET_W'(MAX_EDGES));
  assign e0          = CUR_W'(edge_total_q) << 1;
  assign e1          = e0 + CUR_W'(1);
  assign emit_ok     = !hold_v_q || !of_full;
  assign nb_fresh    = !visited_q[nb_rdata_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(kind_i))
            KIND_ADD:   state_d = (range_ok && !edge_full) ? ST_ADD_A : ST_IDLE;
            KIND_RUN:   state_d = mode_q ? ST_DFS_INIT : ST_BFS_POP;
            KIND_CLEAR: state_d = ST_IDLE;
            KIND_NONE:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_A:    state_d = ST_ADD_B;
      ST_ADD_B:    state_d = ST_ADD_C;
      ST_ADD_C:    state_d = ST_IDLE;
      ST_BFS_POP:  state_d = (rd_q == wr_q) ? ST_RUN_END : ST_BFS_HEAD;
      ST_BFS_HEAD: state_d = emit_ok ? ST_BFS_CUR : ST_BFS_HEAD;
      ST_BFS_CUR:  state_d = hv_q ? ST_BFS_NB : ST_BFS_POP;
      ST_BFS_NB:   state_d = (lk_rdata_q == NIL_ENTRY) ? ST_BFS_POP : ST_BFS_NB;
      ST_DFS_INIT: state_d = ST_DFS_STEP;
      ST_DFS_STEP: begin
        priority if (depth_q == '0) begin
          state_d = ST_RUN_END;
        end else if (top_q == NIL_ENTRY) begin
          state_d = (depth_q > CNT_W'(1)) ? ST_DFS_POP : ST_RUN_END;
        end else begin
          state_d = ST_DFS_NB;
        end
      end
      ST_DFS_POP:  state_d = ST_DFS_STEP;
      ST_DFS_NB: begin
        if (nb_fresh && depth_q < CNT_W'(MAX_NODES)) begin
          state_d = emit_ok ? ST_DFS_PUSH : ST_DFS_NB;
        end else begin
          state_d = ST_DFS_STEP;
        end
      end
      ST_DFS_PUSH: state_d = ST_DFS_STEP;
      ST_RUN_END:  state_d = of_full ? ST_RUN_END : ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    valid_d = valid_q;  visited_d = visited_q;
    edge_total_d = edge_total_q;  ovf_d = ovf_q;
    a_d = a_q;  b_d = b_q;  rd_d = rd_q;  wr_d = wr_q;  depth_d = depth_q;
    top_d = top_q;  hv_d = hv_q;  hold_v_d = hold_v_q;  hold_d = hold_q;
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_re = 1'b0; hd_ra = '0;
    tl_we = 1'b0; tl_wa = '0; tl_wd = '0; tl_re = 1'b0; tl_ra = '0;
    nb_we = 1'b0; nb_wa = '0; nb_wd = '0;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
    en_re = 1'b0; en_ra = '0;
    fq_we = 1'b0; fq_wa = '0; fq_wd = '0; fq_re = 1'b0; fq_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0; st_re = 1'b0; st_ra = '0;
    of_push = 1'b0;
    of_data = '{vertex: hold_q, last: 1'b0, dropped: ovf_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(kind_i))
            KIND_ADD: begin
              if (range_ok) begin
                if (edge_full) begin
                  ovf_d = 1'b1;
                end else begin
                  nb_we = 1'b1; nb_wa = e0[EA_W-1:0]; nb_wd = end_b_i;
                  lk_we = 1'b1; lk_wa = e0[EA_W-1:0]; lk_wd = NIL_ENTRY;
                  tl_re = 1'b1; tl_ra = end_a_i;
                  a_d = end_a_i; b_d = end_b_i;
                end
              end
            end
            KIND_RUN: begin
              visited_d    = '0;
              visited_d[0] = 1'b1;
              if (!mode_q) begin
                fq_we = 1'b1; fq_wa = '0; fq_wd = '0;
                wr_d = CNT_W'(1); rd_d = '0;
              end else begin
                hold_v_d = 1'b1; hold_d = '0;
                hd_re = 1'b1; hd_ra = '0; hv_d = valid_q[0];
                depth_d = CNT_W'(1);
              end
            end
            KIND_CLEAR: begin
              valid_d = '0; edge_total_d = '0; ovf_d = 1'b0;
            end
            KIND_NONE: ;
          endcase
        end
      end
      ST_ADD_A: begin
        if (valid_q[a_q]) begin
          lk_we = 1'b1; lk_wa = tl_rdata_q[EA_W-1:0]; lk_wd = e0;
        end else begin
          hd_we = 1'b1; hd_wa = a_q; hd_wd = e0;
        end
        tl_we = 1'b1; tl_wa = a_q; tl_wd = e0;
        valid_d[a_q] = 1'b1;
        nb_we = 1'b1; nb_wa = e1[EA_W-1:0]; nb_wd = a_q;
      end
      ST_ADD_B: begin
        lk_we = 1'b1; lk_wa = e1[EA_W-1:0]; lk_wd = NIL_ENTRY;
        tl_re = 1'b1; tl_ra = b_q;
      end
      ST_ADD_C: begin
        if (valid_q[b_q]) begin
          lk_we = 1'b1; lk_wa = tl_rdata_q[EA_W-1:0]; lk_wd = e1;
        end else begin
          hd_we = 1'b1; hd_wa = b_q; hd_wd = e1;
        end
        tl_we = 1'b1; tl_wa = b_q; tl_wd = e1;
        valid_d[b_q] = 1'b1;
        edge_total_d = edge_total_q + ET_W'(1);
      end
      ST_BFS_POP: begin
        if (rd_q != wr_q) begin
          fq_re = 1'b1; fq_ra = rd_q[NA_W-1:0];
          rd_d  = rd_q + CNT_W'(1);
        end
      end
      ST_BFS_HEAD: begin
        if (emit_ok) begin
          of_push  = hold_v_q;
          hold_v_d = 1'b1; hold_d = fq_rdata_q;
          hd_re = 1'b1; hd_ra = fq_rdata_q; hv_d = valid_q[fq_rdata_q];
        end
      end
      ST_BFS_CUR: begin
        if (hv_q) begin
          en_re = 1'b1; en_ra = hd_rdata_q[EA_W-1:0];
        end
      end
      ST_BFS_NB: begin
        if (nb_fresh && wr_q < CNT_W'(MAX_NODES)) begin
          visited_d[nb_rdata_q] = 1'b1;
          fq_we = 1'b1; fq_wa = wr_q[NA_W-1:0]; fq_wd = nb_rdata_q;
          wr_d  = wr_q + CNT_W'(1);
        end
        if (lk_rdata_q != NIL_ENTRY) begin
          en_re = 1'b1; en_ra = lk_rdata_q[EA_W-1:0];
        end
      end
      ST_DFS_INIT: top_d = hv_q ? hd_rdata_q : NIL_ENTRY;
      ST_DFS_STEP: begin
        if (depth_q != '0) begin
          if (top_q == NIL_ENTRY) begin
            depth_d = depth_q - CNT_W'(1);
            if (depth_q > CNT_W'(1)) begin
              st_re = 1'b1; st_ra = NA_W'(depth_q - CNT_W'(2));
            end
          end else begin
            en_re = 1'b1; en_ra = top_q[EA_W-1:0];
          end
        end
      end
      ST_DFS_POP: top_d = st_rdata_q;
      ST_DFS_NB: begin
        if (nb_fresh && depth_q < CNT_W'(MAX_NODES)) begin
          if (emit_ok) begin
            top_d = lk_rdata_q;
            visited_d[nb_rdata_q] = 1'b1;
            of_push  = hold_v_q;
            hold_v_d = 1'b1; hold_d = nb_rdata_q;
            st_we = 1'b1; st_wa = NA_W'(depth_q - CNT_W'(1)); st_wd = lk_rdata_q;
            hd_re = 1'b1; hd_ra = nb_rdata_q; hv_d = valid_q[nb_rdata_q];
            depth_d = depth_q + CNT_W'(1);
          end
        end else begin
          top_d = lk_rdata_q;
        end
      end
      ST_DFS_PUSH: top_d = hv_q ? hd_rdata_q : NIL_ENTRY;
      ST_RUN_END: begin
        if (!of_full) begin
          of_push = 1'b1;
          of_data.last = 1'b1;
          hold_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= 1'b0;
      valid_q      <= '0;
      visited_q    <= '0;
      edge_total_q <= '0;
      ovf_q        <= 1'b0;
      rd_q         <= '0;
      wr_q         <= '0;
      depth_q      <= '0;
      hold_v_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      valid_q      <= valid_d;
      visited_q    <= visited_d;
      edge_total_q <= edge_total_d;
      ovf_q        <= ovf_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      depth_q      <= depth_d;
      hold_v_q     <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    top_q  <= top_d;
    hv_q   <= hv_d;
    hold_q <= hold_d;
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    if (hd_re) hd_rdata_q <= head_mem[hd_ra];
    if (tl_we) tail_mem[tl_wa] <= tl_wd;
    if (tl_re) tl_rdata_q <= tail_mem[tl_ra];
    if (nb_we) nb_mem[nb_wa] <= nb_wd;
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    if (en_re) begin
      nb_rdata_q <= nb_mem[en_ra];
      lk_rdata_q <= link_mem[en_ra];
    end
    if (fq_we) fifo_mem[fq_wa] <= fq_wd;
    if (fq_re) fq_rdata_q <= fifo_mem[fq_ra];
    if (st_we) stack_mem[st_wa] <= st_wd;
    if (st_re) st_rdata_q <= stack_mem[st_ra];
  end

  gbdo_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (of_push),
    .data_i  (of_data),
    .full_o  (of_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (of_out)
  );

  assign vertex_o        = of_out.vertex;
  assign last_o          = of_out.last;
  assign edges_dropped_o = of_out.dropped;

  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_q <= wr_q)
    else $error("queue read pointer passed write pointer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   edge_total_q <= ET_W'(MAX_EDGES))
    else $error("edge count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   depth_q <= CNT_W'(MAX_NODES))
    else $error("walk stack overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_RUN_END) |-> hold_v_q)
    else $error("run ended with no vertex held");

endmodule
